[design/nsr_pkg.sv]
`default_nettype none

package nsr_pkg;

    localparam int PREFIX_LEN = 6;
    localparam int MAX_OUT    = 8;

    // Field that holds the satellite count in a GGA line, counted from one.
    localparam logic [3:0] SAT_FIELD = 4'd8;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;

    // Known line prefixes; the last one is the line that gets rewritten.
    localparam logic [7:0] KNOWN_PFX [3][PREFIX_LEN] = '{
        '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_S, CH_A},
        '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_S, CH_V},
        '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A}
    };

    // Checksum of the GGA prefix; the leading '$' does not count.
    localparam logic [7:0] GGA_XOR = CH_G ^ CH_P ^ CH_G ^ CH_G ^ CH_A;

    localparam logic [11:0] IDLE_RST  = 12'd0;
    localparam logic [15:0] IDLE_INIT = 16'd3000;
    localparam logic [11:0] BURST_INIT = 12'd449;

    // All result bytes caused by one input item.
    typedef struct packed {
        logic [3:0]                  count;
        logic [MAX_OUT-1:0][7:0]     bytes;
    } rec_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
    } enq_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = CH_ZERO + {4'd0, v};
        else
            r = CH_A + {4'd0, v} - 8'd10;
        return r;
    endfunction

endpackage

`default_nettype wire

[design/nmea_sentence_rewriter.sv]
// NMEA sentence rewriter.
// Input side is a queue write port: a beat (kind, in_byte) is taken when push
// is high and full is low. kind 0 carries a received character, kind 1 an
// idle tick that counts toward the end of a burst.
// Result side is a queue read port: while empty is low, out_byte and last
// show the oldest waiting character; pop takes it. last marks the final
// character caused by one input beat.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 = idle_limit,
// 1 = burst_limit) and cfg_data; cfg_ready is always high.
// A beat's characters, if any, are written into the record queue when it is taken.
// Throughput: one input beat per cycle while full is low. A beat producing
// k characters keeps the output serializer busy for k pops; up to QUEUE_DEPTH
// such records wait between the classifier and the serializer, so full
// rises only when the receiver stalls or falls behind and the queue has filled.
// Reset clears the line state, counters and queue and loads the default
// limits; no clearing pass is needed.
`default_nettype none

module nmea_sentence_rewriter
    import nsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        kind,
    input  wire logic [7:0]  in_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic CFG_IDLE_LIMIT  = 1'b0;
    localparam logic CFG_BURST_LIMIT = 1'b1;

    logic [15:0] idle_limit_reg;
    logic [11:0] burst_limit_reg;
    logic        accept;
    logic        q_full;
    logic        q_empty;
    logic        deq;
    enq_t        enq;
    rec_t        head;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg  <= IDLE_INIT;
            burst_limit_reg <= BURST_INIT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDLE_LIMIT:  idle_limit_reg  <= cfg_data;
                CFG_BURST_LIMIT: burst_limit_reg <= cfg_data[11:0];
                default:         idle_limit_reg  <= idle_limit_reg;
            endcase
        end
    end

    // The classifier takes a beat whenever the record queue has room, even
    // if the beat turns out to produce nothing.
    assign full   = q_full;
    assign accept = push && !q_full;

    nsr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (kind),
        .in_byte     (in_byte),
        .idle_limit  (idle_limit_reg),
        .burst_limit (burst_limit_reg),
        .enq         (enq)
    );

    nsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .enq   (enq),
        .deq   (deq),
        .head  (head),
        .full  (q_full),
        .empty (q_empty)
    );

    // The serializer walks through the head record one character per pop.
    nsr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .deq      (deq),
        .empty    (empty),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

`default_nettype wire

[design/nsr_front.sv]
`default_nettype none

module nsr_front
    import nsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        kind,
    input  wire logic [7:0]  in_byte,
    input  wire logic [15:0] idle_limit,
    input  wire logic [11:0] burst_limit,
    output enq_t             enq
);

    localparam logic [2:0] MODE_START     = 3'd0;
    localparam logic [2:0] MODE_PASS      = 3'd1;
    localparam logic [2:0] MODE_DROP      = 3'd2;
    localparam logic [2:0] MODE_GGA       = 3'd3;
    localparam logic [2:0] MODE_SAT_FIRST = 3'd4;
    localparam logic [2:0] MODE_SKIP      = 3'd5;

    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  pcount_reg, pcount_next;
    logic [3:0]  field_reg, field_next;
    logic [7:0]  xor_reg, xor_next;
    logic        held_v_reg, held_v_next;
    logic [7:0]  held_reg, held_next;
    logic [1:0]  skip_reg, skip_next;
    logic [15:0] idle_reg, idle_next;
    logic [11:0] burst_reg, burst_next;
    logic [7:0]  store_reg [PREFIX_LEN];

    logic [7:0]  view [PREFIX_LEN];
    logic [7:0]  ob [MAX_OUT];
    logic [3:0]  n;
    logic [2:0]  cnt_new;
    logic [2:0]  pfx_hit;
    logic        do_gga;
    logic        do_close;
    logic        store_wr;

    // Prefix bytes as they stand after this item, the new byte included.
    always_comb
    begin
        for (int i = 0; i < PREFIX_LEN; i++)
        begin
            if (!kind && mode_reg == MODE_START && pcount_reg == 3'(i))
                view[i] = in_byte;
            else
                view[i] = store_reg[i];
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pcount_next = pcount_reg;
        field_next  = field_reg;
        xor_next    = xor_reg;
        held_v_next = held_v_reg;
        held_next   = held_reg;
        skip_next   = skip_reg;
        idle_next   = idle_reg;
        burst_next  = burst_reg;
        n           = 4'd0;
        do_gga      = 1'b0;
        do_close    = 1'b0;
        store_wr    = 1'b0;
        cnt_new     = pcount_reg + 3'd1;
        pfx_hit     = 3'b111;
        for (int i = 0; i < MAX_OUT; i++)
            ob[i] = 8'd0;

        for (int p = 0; p < 3; p++)
            for (int i = 0; i < PREFIX_LEN; i++)
                if (3'(i) < cnt_new && view[i] != KNOWN_PFX[p][i])
                    pfx_hit[p] = 1'b0;

        if (!kind)
        begin
            idle_next = 16'd0;
            if (burst_reg != 12'hFFF)
                burst_next = burst_reg + 12'd1;

            unique case (mode_reg)
                MODE_PASS:
                begin
                    ob[n[2:0]] = in_byte;
                    n = n + 4'd1;
                    if (in_byte == CH_LF)
                    begin
                        mode_next   = MODE_START;
                        pcount_next = 3'd0;
                        field_next  = 4'd1;
                        xor_next    = 8'd0;
                        held_v_next = 1'b0;
                        skip_next   = 2'd0;
                    end
                end
                MODE_DROP:
                begin
                    if (in_byte == CH_LF)
                    begin
                        mode_next   = MODE_START;
                        pcount_next = 3'd0;
                        field_next  = 4'd1;
                        xor_next    = 8'd0;
                        held_v_next = 1'b0;
                        skip_next   = 2'd0;
                    end
                end
                MODE_GGA:
                begin
                    if (held_v_reg)
                    begin
                        if (in_byte == CH_COMMA)
                        begin
                            ob[n[2:0]] = CH_ZERO;
                            n = n + 4'd1;
                            xor_next = xor_next ^ CH_ZERO;
                        end
                        ob[n[2:0]] = held_reg;
                        n = n + 4'd1;
                        held_v_next = 1'b0;
                    end
                    do_gga = 1'b1;
                end
                MODE_SAT_FIRST:
                begin
                    if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
                    begin
                        xor_next    = xor_next ^ in_byte;
                        held_v_next = 1'b1;
                        held_next   = in_byte;
                        mode_next   = MODE_GGA;
                    end
                    else
                        do_gga = 1'b1;
                end
                MODE_SKIP:
                begin
                    if (skip_reg != 2'd0)
                        skip_next = skip_reg - 2'd1;
                    if (skip_next == 2'd0)
                    begin
                        mode_next   = MODE_START;
                        pcount_next = 3'd0;
                        field_next  = 4'd1;
                        xor_next    = 8'd0;
                        held_v_next = 1'b0;
                    end
                end
                default:
                begin
                    // Line start: collect the prefix until it is decided.
                    store_wr    = 1'b1;
                    pcount_next = cnt_new;
                    if (pfx_hit == 3'b000)
                    begin
                        for (int i = 0; i < PREFIX_LEN; i++)
                            if (3'(i) < cnt_new)
                            begin
                                ob[n[2:0]] = view[i];
                                n = n + 4'd1;
                            end
                        pcount_next = 3'd0;
                        if (in_byte == CH_LF)
                        begin
                            mode_next   = MODE_START;
                            field_next  = 4'd1;
                            xor_next    = 8'd0;
                            held_v_next = 1'b0;
                            skip_next   = 2'd0;
                        end
                        else
                            mode_next = MODE_PASS;
                    end
                    else if (cnt_new == 3'(PREFIX_LEN))
                    begin
                        pcount_next = 3'd0;
                        if (pfx_hit[2] && !pfx_hit[1] && !pfx_hit[0])
                        begin
                            field_next = 4'd1;
                            xor_next   = GGA_XOR;
                            mode_next  = MODE_GGA;
                            for (int i = 0; i < PREFIX_LEN; i++)
                            begin
                                ob[n[2:0]] = view[i];
                                n = n + 4'd1;
                            end
                        end
                        else
                            mode_next = MODE_DROP;
                    end
                end
            endcase

            if (do_gga)
            begin
                if (in_byte != CH_DOLLAR && in_byte != CH_STAR)
                    xor_next = xor_next ^ in_byte;
                ob[n[2:0]] = in_byte;
                n = n + 4'd1;
                priority if (in_byte == CH_STAR)
                begin
                    ob[n[2:0]] = hex_char(xor_next[7:4]);
                    n = n + 4'd1;
                    ob[n[2:0]] = hex_char(xor_next[3:0]);
                    n = n + 4'd1;
                    ob[n[2:0]] = CH_CR;
                    n = n + 4'd1;
                    skip_next = 2'd3;
                    mode_next = MODE_SKIP;
                end
                else if (in_byte == CH_COMMA)
                begin
                    if (field_next != 4'd0)
                        field_next = (field_next == 4'd15) ? 4'd0 : field_next + 4'd1;
                    mode_next = (field_next == SAT_FIELD) ? MODE_SAT_FIRST : MODE_GGA;
                end
                else if (in_byte == CH_LF)
                begin
                    mode_next   = MODE_START;
                    pcount_next = 3'd0;
                    field_next  = 4'd1;
                    xor_next    = 8'd0;
                    held_v_next = 1'b0;
                    skip_next   = 2'd0;
                end
                else
                    mode_next = MODE_GGA;
            end

            if (burst_next >= burst_limit)
                do_close = 1'b1;
        end
        else if (burst_reg != 12'd0)
        begin
            if (idle_reg != 16'hFFFF)
                idle_next = idle_reg + 16'd1;
            if (idle_next >= idle_limit)
                do_close = 1'b1;
        end

        if (do_close)
        begin
            if (mode_next == MODE_START)
                for (int i = 0; i < PREFIX_LEN; i++)
                    if (3'(i) < pcount_next)
                    begin
                        ob[n[2:0]] = view[i];
                        n = n + 4'd1;
                    end
            if (held_v_next)
            begin
                ob[n[2:0]] = held_next;
                n = n + 4'd1;
            end
            mode_next   = MODE_START;
            pcount_next = 3'd0;
            field_next  = 4'd1;
            xor_next    = 8'd0;
            held_v_next = 1'b0;
            skip_next   = 2'd0;
            idle_next   = 16'd0;
            burst_next  = 12'd0;
        end
    end

    always_comb
    begin
        enq.valid     = accept && (n != 4'd0);
        enq.rec.count = n;
        for (int i = 0; i < MAX_OUT; i++)
            enq.rec.bytes[i] = ob[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_START;
            pcount_reg <= 3'd0;
            field_reg  <= 4'd1;
            xor_reg    <= 8'd0;
            held_v_reg <= 1'b0;
            skip_reg   <= 2'd0;
            idle_reg   <= 16'd0;
            burst_reg  <= IDLE_RST;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pcount_reg <= pcount_next;
            field_reg  <= field_next;
            xor_reg    <= xor_next;
            held_v_reg <= held_v_next;
            skip_reg   <= skip_next;
            idle_reg   <= idle_next;
            burst_reg  <= burst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
            if (store_wr)
                store_reg[pcount_reg] <= in_byte;
        end
    end

endmodule

`default_nettype wire

[design/nsr_queue.sv]
`default_nettype none

module nsr_queue
    import nsr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire enq_t enq,
    input  wire logic deq,
    output rec_t      head,
    output logic      full,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          slot_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr;
    logic          do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rptr_reg];
    assign do_wr = enq.valid && !full;
    assign do_rd = deq && !empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        if (do_rd)
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= enq.rec;
    end

endmodule

`default_nettype wire

[design/nsr_back.sv]
`default_nettype none

module nsr_back
    import nsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rec_t       head,
    input  wire logic       q_empty,
    input  wire logic       pop,
    output logic            deq,
    output logic            empty,
    output logic [7:0]      out_byte,
    output logic            last
);

    logic [2:0] idx_reg, idx_next;
    logic       take;

    assign empty    = q_empty;
    assign out_byte = head.bytes[idx_reg];
    assign last     = (({1'b0, idx_reg} + 4'd1) == head.count);
    assign take     = pop && !q_empty;
    assign deq      = take && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 3'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench;
    import nsr_pkg::*;

    // Codes for the kind field of an input beat.
    localparam logic K_BYTE = 1'b0;
    localparam logic K_TICK = 1'b1;

    // Indexes of the two limit registers on the configuration channel.
    localparam logic REG_IDLE_LIMIT  = 1'b0;
    localparam logic REG_BURST_LIMIT = 1'b1;

    // Rows of the known prefix table in the package.
    localparam int PFX_GSA = 0;
    localparam int PFX_GSV = 1;
    localparam int PFX_GGA = 2;

    localparam int PHASE_ITEMS = 78;
    localparam int HOLD_CYCLES = 150;

    // Line states of the rewriter, as the predictor tracks them.
    typedef enum logic [2:0] {
        LS_START,
        LS_PASS,
        LS_DROP,
        LS_GGA,
        LS_SAT,
        LS_SKIP
    } line_state_e;

    // One character leaving the block, with its end-of-item mark.
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_beat_t;

    // One row of the directed table. Where fixed_exp is set, the expected
    // result is typed in: exp_cnt says whether one character comes out,
    // and exp_ch is that character. Other rows use the predictor.
    typedef struct packed {
        logic       fixed_exp;
        logic       exp_cnt;
        logic       knd;
        logic [7:0] dat;
        logic [7:0] exp_ch;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        kind = K_BYTE;
    logic [7:0]  in_byte = 8'h00;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = REG_IDLE_LIMIT;
    logic [15:0] cfg_data = 16'h0000;
    wire logic   full;
    wire logic   empty;
    wire logic [7:0] out_byte;
    wire logic   last;
    wire logic   cfg_ready;

    // Side information that travels with each driven beat, so that the
    // monitor knows whether the directed table typed in the result.
    logic        row_fixed = 1'b0;
    logic        row_cnt = 1'b0;
    logic [7:0]  row_ch = 8'h00;

    nmea_sentence_rewriter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .in_byte   (in_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the line state, the counters of
    // the current burst and the two limits.
    // ------------------------------------------------------------------
    line_state_e lstate;
    logic [7:0]  pfx_buf [PREFIX_LEN];
    int          pfx_len;
    logic [3:0]  field_idx;
    logic [7:0]  csum;
    logic        held_ok;
    logic [7:0]  held_char;
    int          skip_cnt;
    int          idle_ticks;
    int          burst_bytes;
    int          idle_lim;
    int          burst_lim;

    // Characters produced by the item being predicted, and the ordered
    // store of characters that the block still owes.
    logic [7:0]  step_out [$];
    char_beat_t  expected_chars [$];
    char_beat_t  head;
    char_beat_t  beat;

    int          mismatch_count = 0;
    int          items_sent = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    stim_row_t   dir_rows [25];

    function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
        if (v < 4'd10)
            return CH_ZERO + {4'd0, v};
        return CH_A + {4'd0, v} - 8'd10;
    endfunction

    // One item never yields more than MAX_OUT characters; extra ones are lost.
    function automatic void emit_char(input logic [7:0] c);
        if (step_out.size() < MAX_OUT)
            step_out.push_back(c);
    endfunction

    function automatic void restart_line();
        lstate    = LS_START;
        pfx_len   = 0;
        field_idx = 4'd1;
        csum      = 8'h00;
        held_ok   = 1'b0;
        held_char = 8'h00;
        skip_cnt  = 0;
    endfunction

    // A character of a GGA line: it enters the checksum unless it is a
    // dollar or a star, and a star closes the line with the new checksum.
    function automatic void gga_char(input logic [7:0] c);
        if (c != CH_DOLLAR && c != CH_STAR)
            csum ^= c;
        emit_char(c);
        if (c == CH_STAR) begin
            emit_char(nibble_ascii(csum[7:4]));
            emit_char(nibble_ascii(csum[3:0]));
            emit_char(CH_CR);
            skip_cnt = 3;
            lstate   = LS_SKIP;
        end else if (c == CH_COMMA) begin
            // The field count parks at zero once it runs past fifteen.
            if (field_idx != 4'd0)
                field_idx = (field_idx >= 4'd15) ? 4'd0 : field_idx + 4'd1;
            lstate = (field_idx == SAT_FIELD) ? LS_SAT : LS_GGA;
        end else if (c == CH_LF) begin
            restart_line();
        end else begin
            lstate = LS_GGA;
        end
    endfunction

    function automatic void route_char(input logic [7:0] c);
        int hit;
        int n;
        bit ok;
        case (lstate)
            LS_PASS: begin
                emit_char(c);
                if (c == CH_LF)
                    restart_line();
            end
            LS_DROP: begin
                if (c == CH_LF)
                    restart_line();
            end
            LS_GGA: begin
                // A single held satellite digit gets its leading zero only
                // when the field ends right after it.
                if (held_ok) begin
                    if (c == CH_COMMA) begin
                        emit_char(CH_ZERO);
                        csum ^= CH_ZERO;
                    end
                    emit_char(held_char);
                    held_ok   = 1'b0;
                    held_char = 8'h00;
                end
                gga_char(c);
            end
            LS_SAT: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    csum ^= c;
                    held_ok   = 1'b1;
                    held_char = c;
                    lstate    = LS_GGA;
                end else begin
                    gga_char(c);
                end
            end
            LS_SKIP: begin
                if (skip_cnt > 0)
                    skip_cnt--;
                if (skip_cnt == 0)
                    restart_line();
            end
            default: begin
                // Collect the prefix and decide as soon as it can no longer
                // match any known one or is complete.
                if (pfx_len < PREFIX_LEN) begin
                    pfx_buf[pfx_len] = c;
                    pfx_len++;
                end
                hit = -1;
                for (int p = 0; p < 3; p++) begin
                    ok = 1'b1;
                    for (int i = 0; i < pfx_len; i++)
                        if (pfx_buf[i] != KNOWN_PFX[p][i])
                            ok = 1'b0;
                    if (ok && hit < 0)
                        hit = p;
                end
                if (hit < 0) begin
                    for (int i = 0; i < pfx_len; i++)
                        emit_char(pfx_buf[i]);
                    if (c == CH_LF) begin
                        restart_line();
                    end else begin
                        pfx_len = 0;
                        lstate  = LS_PASS;
                    end
                end else if (pfx_len >= PREFIX_LEN) begin
                    n       = pfx_len;
                    pfx_len = 0;
                    if (hit == PFX_GGA) begin
                        field_idx = 4'd1;
                        csum      = 8'h00;
                        for (int i = 0; i < n; i++)
                            gga_char(pfx_buf[i]);
                    end else begin
                        lstate = LS_DROP;
                    end
                end
            end
        endcase
    endfunction

    // End of a burst: undecided prefix bytes and a held digit go out as
    // they are, and the line starts over.
    function automatic void end_burst();
        if (lstate == LS_START)
            for (int i = 0; i < pfx_len; i++)
                emit_char(pfx_buf[i]);
        if (held_ok)
            emit_char(held_char);
        restart_line();
        idle_ticks  = 0;
        burst_bytes = 0;
    endfunction

    function automatic void rewrite_step(input logic k, input logic [7:0] b);
        step_out.delete();
        if (k == K_BYTE) begin
            idle_ticks = 0;
            if (burst_bytes < 4095)
                burst_bytes++;
            route_char(b);
            if (burst_bytes >= burst_lim)
                end_burst();
        end else if (burst_bytes > 0) begin
            // Ticks only count while a burst is open.
            if (idle_ticks < 65535)
                idle_ticks++;
            if (idle_ticks >= idle_lim)
                end_burst();
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the driver's
    // values have been stable for half a period. Results are checked
    // before the new input beat adds its own expectations, so a result can
    // never be matched against characters of the beat taken at the same
    // edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_IDLE_LIMIT)
                    idle_lim = int'(cfg_data);
                else
                    burst_lim = int'(cfg_data[11:0]);
            end
            if (pop && !empty) begin
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: out_byte=%h last=%b",
                                 out_byte, last);
                end else begin
                    head = expected_chars.pop_front();
                    if (out_byte !== head.ch || last !== head.fin) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected out_byte=%h last=%b, got out_byte=%h last=%b",
                                     head.ch, head.fin, out_byte, last);
                    end
                end
            end
            if (push && !full) begin
                rewrite_step(kind, in_byte);
                if (row_fixed) begin
                    if (row_cnt) begin
                        beat.ch  = row_ch;
                        beat.fin = 1'b1;
                        expected_chars.push_back(beat);
                    end
                end else begin
                    for (int i = 0; i < step_out.size(); i++) begin
                        beat.ch  = step_out[i];
                        beat.fin = (i == step_out.size() - 1);
                        expected_chars.push_back(beat);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It stalls at the rate of the current phase, and on request
    // it holds off for a long stretch so that the block backs up and
    // raises full while the sender keeps offering beats.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender. A beat is offered at a falling edge and held until the rising
    // edge that takes it. Within a run of beats, push is only lowered when a gap
    // is chosen, so the run keeps it high without a glitch.
    // ------------------------------------------------------------------
    task automatic send_item(input logic k, input logic [7:0] b, input logic fx,
                             input logic n, input logic [7:0] ch);
        while ($urandom_range(0, 99) < gap_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        kind      <= k;
        in_byte   <= b;
        row_fixed <= fx;
        row_cnt   <= n;
        row_ch    <= ch;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(K_BYTE, b, 1'b0, 1'b0, 8'h00);
    endtask

    task automatic send_prefix(input int p, input int n);
        for (int i = 0; i < n; i++)
            send_byte(KNOWN_PFX[p][i]);
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_letter();
        return CH_A + 8'($urandom_range(0, 25));
    endfunction

    // Field content is mostly digits and dots, with the odd letter and the
    // odd arbitrary byte that may break the line.
    function automatic logic [7:0] field_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return random_digit();
        if (r == 6)
            return 8'h2E;
        if (r < 9)
            return random_letter();
        return 8'($urandom);
    endfunction

    // One line of random content. Most lines are well formed so that the
    // GGA rewrite and the drop of GSA and GSV lines are reached; the rest
    // are foreign lines, cut prefixes and noise.
    task automatic send_line();
        int pick;
        int nf;
        int r;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_prefix(PFX_GGA, PREFIX_LEN);
            nf = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18)
                                              : $urandom_range(6, 10);
            for (int k = 1; k <= nf; k++) begin
                send_byte(CH_COMMA);
                if (k + 1 == int'(SAT_FIELD)) begin
                    // Satellite field: one digit, two digits, empty, or odd.
                    r = $urandom_range(0, 9);
                    if (r < 5) begin
                        send_byte(random_digit());
                    end else if (r < 7) begin
                        send_byte(random_digit());
                        send_byte(random_digit());
                    end else if (r == 8) begin
                        send_byte(random_letter());
                    end else if (r == 9) begin
                        send_byte(8'($urandom));
                    end
                end else begin
                    repeat ($urandom_range(0, 2))
                        send_byte(field_char());
                end
            end
            r = $urandom_range(0, 9);
            if (r < 8) begin
                send_byte(CH_STAR);
                send_byte(nibble_ascii(4'($urandom)));
                send_byte(nibble_ascii(4'($urandom)));
                send_byte(CH_CR);
                send_byte(CH_LF);
            end else if (r == 8) begin
                send_byte(CH_LF);
            end
        end else if (pick < 60) begin
            send_prefix(($urandom_range(0, 1) == 0) ? PFX_GSA : PFX_GSV, PREFIX_LEN);
            repeat ($urandom_range(0, 5))
                send_byte(field_char());
            send_byte(CH_LF);
        end else if (pick < 75) begin
            send_prefix($urandom_range(0, 2), 3);
            repeat (3)
                send_byte(random_letter());
            repeat ($urandom_range(0, 4))
                send_byte(field_char());
            send_byte(CH_CR);
            send_byte(CH_LF);
        end else if (pick < 85) begin
            send_prefix($urandom_range(0, 2), $urandom_range(1, 5));
            r = $urandom_range(0, 2);
            if (r == 0)
                send_byte(CH_LF);
            else if (r == 1)
                send_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom));
        end
        // Idle ticks between lines close bursts when the idle limit is low.
        if ($urandom_range(0, 99) < 40)
            repeat ($urandom_range(1, 6))
                send_item(K_TICK, 8'($urandom), 1'b0, 1'b0, 8'h00);
    endtask

    // Waits until the block owes nothing, then waits on so that beats that
    // produce no characters can work through.
    task automatic settle();
        while (expected_chars.size() != 0)
            @(negedge clk);
        repeat (16)
            @(negedge clk);
    endtask

    // One random phase: set both limits while the block is idle, choose the
    // idling of both sides, then send lines until the item count is reached.
    task automatic run_phase(input logic [15:0] idle_val, input logic [11:0] burst_val,
                             input int gap, input int stall, input bit hold_off,
                             input bit mid_pause);
        int start;
        bit paused;
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_IDLE_LIMIT;
        cfg_data  <= idle_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_index <= REG_BURST_LIMIT;
        cfg_data  <= {4'h0, burst_val};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        gap_pct   = gap;
        stall_pct = stall;
        if (hold_off)
            hold_requests++;
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < PHASE_ITEMS) begin
            if (mid_pause && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
                // The sender stops until every owed character has come out.
                paused = 1'b1;
                push <= 1'b0;
                @(negedge clk);
                while (expected_chars.size() != 0)
                    @(negedge clk);
            end
            send_line();
        end
        push <= 1'b0;
    endtask

    initial begin
        int waited;
        lstate      = LS_START;
        restart_line();
        idle_ticks  = 0;
        burst_bytes = 0;
        idle_lim    = int'(IDLE_INIT);
        burst_lim   = int'(BURST_INIT);

        // Directed part, run with the limits left at their reset values.
        // The typed rows are the ones whose result is plain: a tick outside
        // a burst, the extreme byte values passing straight through, and a
        // bare line feed. The GGA line in between goes through the
        // predictor; it has an empty run of fields up to the satellite
        // field, a one-digit satellite count, a tick inside the burst, and
        // a checksum tail that is swallowed.
        dir_rows = '{
            '{1'b1, 1'b0, K_TICK, 8'hA5,     8'h00},
            '{1'b1, 1'b1, K_BYTE, 8'hFF,     8'hFF},
            '{1'b1, 1'b1, K_BYTE, 8'h00,     8'h00},
            '{1'b1, 1'b1, K_BYTE, CH_LF,     CH_LF},
            '{1'b0, 1'b0, K_BYTE, CH_DOLLAR, 8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_G,      8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_P,      8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_G,      8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_G,      8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_A,      8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_COMMA,  8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_COMMA,  8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_COMMA,  8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_COMMA,  8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_COMMA,  8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_COMMA,  8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_COMMA,  8'h00},
            '{1'b0, 1'b0, K_BYTE, 8'h35,     8'h00},
            '{1'b0, 1'b0, K_TICK, 8'h5A,     8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_COMMA,  8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_STAR,   8'h00},
            '{1'b0, 1'b0, K_BYTE, 8'h34,     8'h00},
            '{1'b0, 1'b0, K_BYTE, 8'h37,     8'h00},
            '{1'b0, 1'b0, K_BYTE, CH_CR,     8'h00},
            '{1'b1, 1'b1, K_BYTE, CH_LF,     CH_LF}
        };

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].knd, dir_rows[i].dat, dir_rows[i].fixed_exp,
                      dir_rows[i].exp_cnt, dir_rows[i].exp_ch);
        push <= 1'b0;

        // Widest limits with no idling, plus a long receiver hold-off that
        // backs the block up against its input.
        run_phase(16'd65535, 12'd4095, 0, 0, 1'b1, 1'b0);
        // Narrow limits: every second byte closes the burst, and a
        // single tick does too. The sender idles most of the time.
        run_phase(16'd1, 12'd2, 83, 0, 1'b0, 1'b0);
        // Bursts long enough for a GGA line to be cut mid-way; the receiver
        // stalls most of the time.
        run_phase(16'd5, 12'd40, 0, 83, 1'b0, 1'b0);
        // Both sides idle a little, with a pause for a full drain midway.
        run_phase(16'd2, 12'd120, 10, 10, 1'b0, 1'b1);

        gap_pct   = 0;
        stall_pct = 0;
        waited    = 0;
        while (expected_chars.size() != 0 && waited < 50000) begin
            @(negedge clk);
            waited++;
        end
        repeat (20)
            @(negedge clk);
        if (expected_chars.size() != 0)
            $display("%0d expected result beats never arrived", expected_chars.size());
        mismatch_count += expected_chars.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: a correct run ends long before this.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
